// ===== sv/fbcrc8_pkg.sv =====
// ----------------------------------------------------------------------------
// fbcrc8_pkg - shared types and constants of the CRC-8 frame builder
// Queue entry type, front state codes, stuffing codes and the CRC byte step.
// ----------------------------------------------------------------------------
`default_nettype none

package fbcrc8_pkg;

	// Byte codes that force a fill byte after them, and the fill byte
	localparam logic [7:0] STUFF_A    = 8'h81;
	localparam logic [7:0] STUFF_B    = 8'h88;
	localparam logic [7:0] STUFF_FILL = 8'hff;

	// Largest payload size placed in a header
	localparam logic [5:0] PAYLOAD_MAX = 6'd63;

	// Configuration register map
	localparam int unsigned ADDR_W   = 3;
	localparam logic        REG_POLY = 1'b0;
	localparam logic [7:0]  POLY_RESET = 8'h07;

	// Queue between front and back
	localparam int unsigned QUEUE_DEPTH = 4;

	// One raw frame byte handed from front to back
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} entry_t;

	// Front sequencer states
	typedef enum logic [1:0] {
		FS_IDLE,
		FS_H1,
		FS_H2,
		FS_CRC
	} front_state_t;

	// Feed one byte MSB-first into the CRC-8 remainder
	function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] din,
			input logic [7:0] poly);
		logic [7:0] c;
		c = crc ^ din;
		for (int b = 0; b < 8; b++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ poly;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

	// True for bytes that need a fill byte after them
	function automatic logic needs_stuff(input logic [7:0] b);
		return (b == STUFF_A) || (b == STUFF_B);
	endfunction

endpackage

`default_nettype wire

// ===== sv/fbcrc8_front.sv =====
// ----------------------------------------------------------------------------
// fbcrc8_front - item intake and frame sequencing
// Accepts header and payload items, keeps the running CRC and the byte count,
// and pushes raw frame bytes (header, payload, CRC), one per cycle unless q_full.
// ----------------------------------------------------------------------------
`default_nettype none

module fbcrc8_front (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire  [7:0]           crc_polynomial,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  wire                  is_header,
	input  wire  [7:0]           marker,
	input  wire  [5:0]           payload_size,
	input  wire  [4:0]           sequence_req,
	input  wire  [4:0]           msg_type,
	input  wire  [7:0]           data_byte,
	input  wire                  q_full,
	output logic                 push_valid,
	output fbcrc8_pkg::entry_t   push_entry
);

	fbcrc8_pkg::front_state_t state_q, state_d;
	logic       in_frame_q;
	logic [5:0] bytes_left_q;
	logic [7:0] crc_q;
	logic [7:0] h1_q;
	logic [7:0] h2_q;
	logic       size_zero_q;

	logic       accept;
	logic [5:0] size_sat;
	logic [7:0] crc_base;
	logic [7:0] crc_next;

	assign in_ready = (state_q == fbcrc8_pkg::FS_IDLE) && !q_full;
	assign accept   = in_valid && in_ready;

	// Clamp the size to the frame limit
	assign size_sat = (payload_size > fbcrc8_pkg::PAYLOAD_MAX) ?
		fbcrc8_pkg::PAYLOAD_MAX : payload_size;

	// Select the byte to push and the CRC it continues from
	always_comb begin
		push_valid      = 1'b0;
		push_entry.data = 8'h00;
		push_entry.last = 1'b0;
		crc_base        = crc_q;
		case (state_q)
			fbcrc8_pkg::FS_IDLE: begin
				push_valid      = accept && (is_header || in_frame_q);
				push_entry.data = is_header ? marker : data_byte;
				crc_base        = is_header ? 8'h00 : crc_q;
			end
			fbcrc8_pkg::FS_H1: begin
				push_valid      = !q_full;
				push_entry.data = h1_q;
			end
			fbcrc8_pkg::FS_H2: begin
				push_valid      = !q_full;
				push_entry.data = h2_q;
			end
			fbcrc8_pkg::FS_CRC: begin
				push_valid      = !q_full;
				push_entry.data = crc_q;
				push_entry.last = 1'b1;
			end
			default: begin
				push_valid = 1'b0;
			end
		endcase
	end

	assign crc_next = fbcrc8_pkg::crc_feed(crc_base, push_entry.data, crc_polynomial);

	// Advance the sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			fbcrc8_pkg::FS_IDLE: begin
				if (accept && is_header) begin
					state_d = fbcrc8_pkg::FS_H1;
				end else if (accept && in_frame_q && (bytes_left_q == 6'd1)) begin
					state_d = fbcrc8_pkg::FS_CRC;
				end
			end
			fbcrc8_pkg::FS_H1: begin
				if (!q_full) begin
					state_d = fbcrc8_pkg::FS_H2;
				end
			end
			fbcrc8_pkg::FS_H2: begin
				if (!q_full) begin
					state_d = size_zero_q ? fbcrc8_pkg::FS_CRC : fbcrc8_pkg::FS_IDLE;
				end
			end
			fbcrc8_pkg::FS_CRC: begin
				if (!q_full) begin
					state_d = fbcrc8_pkg::FS_IDLE;
				end
			end
			default: begin
				state_d = fbcrc8_pkg::FS_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fbcrc8_pkg::FS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Track frame state and running CRC
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q   <= 1'b0;
			bytes_left_q <= 6'd0;
			crc_q        <= 8'h00;
		end else if (push_valid) begin
			if (state_q == fbcrc8_pkg::FS_CRC) begin
				in_frame_q   <= 1'b0;
				bytes_left_q <= 6'd0;
				crc_q        <= 8'h00;
			end else begin
				crc_q <= crc_next;
				if (state_q == fbcrc8_pkg::FS_IDLE) begin
					if (is_header) begin
						in_frame_q   <= 1'b1;
						bytes_left_q <= size_sat;
					end else begin
						bytes_left_q <= bytes_left_q - 6'd1;
					end
				end
			end
		end
	end

	// Hold the remaining header bytes
	always_ff @(posedge clk) begin
		if (accept && is_header) begin
			h1_q        <= {size_sat, sequence_req[4:3]};
			h2_q        <= {sequence_req[2:0], msg_type};
			size_zero_q <= (size_sat == 6'd0);
		end
	end

endmodule

`default_nettype wire

// ===== sv/fbcrc8_queue.sv =====
// ----------------------------------------------------------------------------
// fbcrc8_queue - short byte queue between front and back
// Register-based FIFO of raw frame bytes with their end-of-frame flag.
// ----------------------------------------------------------------------------
`default_nettype none

module fbcrc8_queue #(
	parameter int unsigned DEPTH = fbcrc8_pkg::QUEUE_DEPTH
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push_valid,
	input  fbcrc8_pkg::entry_t   push_entry,
	output logic                 full,
	output logic                 pop_valid,
	input  wire                  pop,
	output fbcrc8_pkg::entry_t   pop_entry
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	fbcrc8_pkg::entry_t mem_q [DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (count_q == CNT_FULL);
	assign pop_valid = (count_q != '0);
	assign pop_entry = mem_q[rptr_q];
	assign do_push   = push_valid && !full;
	assign do_pop    = pop && pop_valid;

	// Store the pushed entry
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= push_entry;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PTR_LAST) ? '0 : wptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PTR_LAST) ? '0 : rptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/fbcrc8_back.sv =====
// ----------------------------------------------------------------------------
// fbcrc8_back - byte stuffing and output register
// Pops raw bytes, drives them on the output channel and inserts a fill byte
// after each stuff code; moves the end-of-frame mark to the fill byte.
// ----------------------------------------------------------------------------
`default_nettype none

module fbcrc8_back (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  pop_valid,
	input  fbcrc8_pkg::entry_t   pop_entry,
	output logic                 pop,
	output logic                 out_valid,
	input  wire                  out_ready,
	output logic [7:0]           out_byte,
	output logic                 frame_end
);

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       frame_end_q;
	logic       stuff_pend_q;
	logic       stuff_last_q;
	logic       load;
	logic       stuff;

	assign load  = !out_valid_q || out_ready;
	assign pop   = load && !stuff_pend_q && pop_valid;
	assign stuff = fbcrc8_pkg::needs_stuff(pop_entry.data);

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign frame_end = frame_end_q;

	// Track output beat and pending fill byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			stuff_pend_q <= 1'b0;
		end else if (load) begin
			if (stuff_pend_q) begin
				out_valid_q  <= 1'b1;
				stuff_pend_q <= 1'b0;
			end else if (pop_valid) begin
				out_valid_q  <= 1'b1;
				stuff_pend_q <= stuff;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Load the output payload
	always_ff @(posedge clk) begin
		if (load) begin
			if (stuff_pend_q) begin
				out_byte_q  <= fbcrc8_pkg::STUFF_FILL;
				frame_end_q <= stuff_last_q;
			end else if (pop_valid) begin
				out_byte_q   <= pop_entry.data;
				frame_end_q  <= pop_entry.last && !stuff;
				stuff_last_q <= pop_entry.last;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/frame_builder_crc8_stuffing_top.sv =====
// ----------------------------------------------------------------------------
// frame_builder_crc8_stuffing_top - CRC-8 framed packet builder with stuffing
// Builds header, payload and CRC bytes of a frame and stuffs 0x81 and 0x88.
// ----------------------------------------------------------------------------
//
//   channel   signals                              beat
//   input     in_valid / in_ready + item fields    one header or payload item
//   output    out_valid / out_ready + out_byte     one frame byte on the wire
//   config    APB psel/penable/pwrite/paddr/...    crc_polynomial at 0x0
//
// A header item holds the front for the marker, H1 and H2 bytes and, with an
// empty payload, the CRC byte; the last payload item holds it for the CRC
// byte. The back sends one beat per cycle while out_ready is high, plus a
// fill beat per stuffed byte. A four-entry byte queue lets each side stall
// on its own. Reset clears the frame state and sets the polynomial to 0x07.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_builder_crc8_stuffing_top #(
	parameter int unsigned QUEUE_DEPTH = fbcrc8_pkg::QUEUE_DEPTH
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           psel,
	input  wire                           penable,
	input  wire                           pwrite,
	input  wire  [fbcrc8_pkg::ADDR_W-1:0] paddr,
	input  wire  [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  wire                           in_valid,
	output logic                          in_ready,
	input  wire                           is_header,
	input  wire  [7:0]                    marker,
	input  wire  [5:0]                    payload_size,
	input  wire  [4:0]                    sequence_req,
	input  wire  [4:0]                    msg_type,
	input  wire  [7:0]                    data_byte,
	output logic                          out_valid,
	input  wire                           out_ready,
	output logic [7:0]                    out_byte,
	output logic                          frame_end
);

	logic [7:0]         crc_polynomial_q;
	logic               reg_sel;
	logic               push_valid;
	fbcrc8_pkg::entry_t push_entry;
	logic               q_full;
	logic               pop_valid;
	logic               pop;
	fbcrc8_pkg::entry_t pop_entry;

	// Decode the register index
	assign pready  = 1'b1;
	assign reg_sel = (paddr[fbcrc8_pkg::ADDR_W-1] == fbcrc8_pkg::REG_POLY);
	assign prdata  = reg_sel ? {24'h000000, crc_polynomial_q} : 32'h00000000;

	// Write the polynomial register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_polynomial_q <= fbcrc8_pkg::POLY_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			crc_polynomial_q <= pwdata[7:0];
		end
	end

	fbcrc8_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.crc_polynomial (crc_polynomial_q),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.is_header      (is_header),
		.marker         (marker),
		.payload_size   (payload_size),
		.sequence_req   (sequence_req),
		.msg_type       (msg_type),
		.data_byte      (data_byte),
		.q_full         (q_full),
		.push_valid     (push_valid),
		.push_entry     (push_entry)
	);

	fbcrc8_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_entry (push_entry),
		.full       (q_full),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_entry  (pop_entry)
	);

	fbcrc8_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_entry (pop_entry),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.frame_end (frame_end)
	);

endmodule

`default_nettype wire
